FILE: src/mcfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mcfe_pkg;

  localparam int NumLanes  = 5;
  localparam int DivSteps  = 16;
  localparam int OffW      = 33;
  localparam int NumW      = 48;
  localparam int RangeW    = 31;
  localparam int IdW       = 11;
  localparam int CfgIdxW   = 3;
  localparam int QDepth    = 4;
  localparam int QIdxW     = 2;

  // Lane order inside the datapath
  localparam int LanePos = 0;
  localparam int LaneVel = 1;
  localparam int LaneKp  = 2;
  localparam int LaneKd  = 3;
  localparam int LaneTq  = 4;

  typedef enum logic [CfgIdxW-1:0] {
    RegMotorId    = 3'd0,
    RegModeOffset = 3'd1,
    RegPosRange   = 3'd2,
    RegVelRange   = 3'd3,
    RegTqRange    = 3'd4,
    RegKpLimit    = 3'd5,
    RegKdLimit    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] target_position;
    logic signed [31:0] target_velocity;
    logic signed [31:0] stiffness_gain;
    logic signed [31:0] damping_gain;
    logic signed [31:0] feedforward_torque;
  } cmd_t;

  typedef struct packed {
    logic [10:0] frame_id;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [7:0]  byte4;
    logic [7:0]  byte5;
    logic [7:0]  byte6;
    logic [7:0]  byte7;
  } frame_t;

  typedef struct packed {
    logic [IdW-1:0]    base_id;
    logic [IdW-1:0]    mode_id_offset;
    logic [RangeW-1:0] pos_limit;
    logic [RangeW-1:0] vel_limit;
    logic [RangeW-1:0] tq_limit;
    logic [RangeW-1:0] stiffness_limit;
    logic [RangeW-1:0] damping_limit;
  } cfg_t;

  // Offsets of the clamped values above their lower bound
  typedef logic [NumLanes-1:0][OffW-1:0] off_word_t;

  typedef struct packed {
    logic [31:0]         rem;
    logic [DivSteps-1:0] sh;
  } div_lane_t;

  typedef div_lane_t [NumLanes-1:0] div_row_t;

  // One restoring division step: shift in a numerator bit, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t d, logic [31:0] span);
    logic [32:0] r2;
    logic [32:0] diff;
    div_lane_t   res;
    r2   = {d.rem, d.sh[DivSteps-1]};
    diff = r2 - {1'b0, span};
    if (r2 >= {1'b0, span}) begin
      res.rem = diff[31:0];
      res.sh  = {d.sh[DivSteps-2:0], 1'b1};
    end else begin
      res.rem = r2[31:0];
      res.sh  = {d.sh[DivSteps-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: src/mcfe_front.sv
`timescale 1ns / 1ps
`default_nettype none
module mcfe_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire mcfe_pkg::cmd_t     in_data,
  input  wire mcfe_pkg::cfg_t     cfg,
  input  wire logic               q_full,
  output logic                    q_push,
  output mcfe_pkg::off_word_t     q_word
);

  logic                 front_valid;
  logic                 take;
  mcfe_pkg::off_word_t  off_next;
  mcfe_pkg::off_word_t  off_reg;

  // Clamp to [-r, r] and offset by r
  function automatic logic [mcfe_pkg::OffW-1:0] sym_off(logic signed [31:0] x,
                                                       logic [mcfe_pkg::RangeW-1:0] r);
    logic signed [32:0] sx;
    logic signed [32:0] rr;
    logic signed [32:0] c;
    sx = {x[31], x};
    rr = {2'b00, r};
    if (sx > rr) c = rr;
    else if (sx < -rr) c = -rr;
    else c = sx;
    return c + rr;
  endfunction

  // Clamp to [0, l]
  function automatic logic [mcfe_pkg::OffW-1:0] gain_off(logic signed [31:0] x,
                                                        logic [mcfe_pkg::RangeW-1:0] l);
    logic [mcfe_pkg::OffW-1:0] res;
    if (x[31]) res = '0;
    else if (x[30:0] > l) res = {2'b00, l};
    else res = {2'b00, x[30:0]};
    return res;
  endfunction

  always_comb begin
    off_next[mcfe_pkg::LanePos] = sym_off(in_data.target_position, cfg.pos_limit);
    off_next[mcfe_pkg::LaneVel] = sym_off(in_data.target_velocity, cfg.vel_limit);
    off_next[mcfe_pkg::LaneKp]  = gain_off(in_data.stiffness_gain, cfg.stiffness_limit);
    off_next[mcfe_pkg::LaneKd]  = gain_off(in_data.damping_gain, cfg.damping_limit);
    off_next[mcfe_pkg::LaneTq]  = sym_off(in_data.feedforward_torque, cfg.tq_limit);
  end

  // Hold the word while the queue is full
  assign in_stall = front_valid & q_full;
  assign take     = in_valid & ~in_stall;
  assign q_push   = front_valid & ~q_full;
  assign q_word   = off_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else begin
      front_valid <= take | (front_valid & q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      off_reg <= off_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/mcfe_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module mcfe_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire mcfe_pkg::off_word_t push_word,
  input  wire logic                pop,
  output mcfe_pkg::off_word_t      head_word,
  output logic                     full,
  output logic                     empty
);

  mcfe_pkg::off_word_t            mem [mcfe_pkg::QDepth];
  logic [mcfe_pkg::QIdxW-1:0]     wr_ptr;
  logic [mcfe_pkg::QIdxW-1:0]     rd_ptr;
  logic [mcfe_pkg::QIdxW:0]       count;

  assign full      = (count == (mcfe_pkg::QIdxW+1)'(mcfe_pkg::QDepth));
  assign empty     = (count == '0);
  assign head_word = mem[rd_ptr];

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + {{mcfe_pkg::QIdxW{1'b0}}, push} - {{mcfe_pkg::QIdxW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (mcfe_pkg::QIdxW+1)'(mcfe_pkg::QDepth))
    else $error("queue count beyond depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow a push");

endmodule
`default_nettype wire

FILE: src/mcfe_back.sv
`timescale 1ns / 1ps
`default_nettype none
module mcfe_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mcfe_pkg::cfg_t      cfg,
  input  wire logic                q_empty,
  input  wire mcfe_pkg::off_word_t q_word,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mcfe_pkg::frame_t         out_data
);

  localparam int Last = mcfe_pkg::DivSteps;

  logic                          adv;
  logic [Last:0]                 sv;
  mcfe_pkg::div_row_t            st [Last+1];
  mcfe_pkg::div_row_t            st0_next;
  logic [mcfe_pkg::NumLanes-1:0][31:0] span;
  logic [mcfe_pkg::NumLanes-1:0][15:0] code;
  mcfe_pkg::frame_t              frame_next;

  // Spans follow the live registers
  always_comb begin
    span[mcfe_pkg::LanePos] = {cfg.pos_limit, 1'b0};
    span[mcfe_pkg::LaneVel] = {cfg.vel_limit, 1'b0};
    span[mcfe_pkg::LaneKp]  = {1'b0, cfg.stiffness_limit};
    span[mcfe_pkg::LaneKd]  = {1'b0, cfg.damping_limit};
    span[mcfe_pkg::LaneTq]  = {cfg.tq_limit, 1'b0};
  end

  // Numerator off * (2^bits - 1) as a shift and subtract
  always_comb begin
    logic [mcfe_pkg::OffW+15:0] num;
    for (int i = 0; i < mcfe_pkg::NumLanes; i++) begin
      if (i == mcfe_pkg::LanePos)
        num = {q_word[i], 16'b0} - {16'b0, q_word[i]};
      else
        num = {4'b0, q_word[i], 12'b0} - {16'b0, q_word[i]};
      st0_next[i].rem = num[mcfe_pkg::NumW-1:16];
      st0_next[i].sh  = num[15:0];
    end
  end

  assign adv   = ~out_valid | ~out_stall;
  assign q_pop = adv & ~q_empty;

  // Advance the divider pipeline as one
  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      sv        <= {sv[Last-1:0], ~q_empty};
      out_valid <= sv[Last];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0] <= st0_next;
      for (int k = 1; k <= Last; k++) begin
        for (int i = 0; i < mcfe_pkg::NumLanes; i++) begin
          st[k][i] <= mcfe_pkg::div_step(st[k-1][i], span[i]);
        end
      end
      out_data <= frame_next;
    end
  end

  // Drop the quotient where the span is zero, then pack
  always_comb begin
    for (int i = 0; i < mcfe_pkg::NumLanes; i++) begin
      code[i] = (span[i] == '0) ? 16'd0 : st[Last][i].sh;
    end
    frame_next.frame_id = cfg.base_id + cfg.mode_id_offset;
    frame_next.byte0    = code[mcfe_pkg::LanePos][15:8];
    frame_next.byte1    = code[mcfe_pkg::LanePos][7:0];
    frame_next.byte2    = code[mcfe_pkg::LaneVel][11:4];
    frame_next.byte3    = {code[mcfe_pkg::LaneVel][3:0], code[mcfe_pkg::LaneKp][11:8]};
    frame_next.byte4    = code[mcfe_pkg::LaneKp][7:0];
    frame_next.byte5    = code[mcfe_pkg::LaneKd][11:4];
    frame_next.byte6    = {code[mcfe_pkg::LaneKd][3:0], code[mcfe_pkg::LaneTq][11:8]};
    frame_next.byte7    = code[mcfe_pkg::LaneTq][7:0];
  end

  a_pop_feeds_stage: assert property (@(posedge clk) disable iff (rst)
    (q_pop) |=> sv[0])
    else $error("popped word not captured");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(sv)))
    else $error("pipeline moved while output stalled");
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !q_pop)
    else $error("queue popped while output stalled");

endmodule
`default_nettype wire

FILE: src/mit_command_frame_encoder.sv
// Throughput: one command per cycle while not stalled; the 16-step restoring divider
// is fully pipelined from the queue to the output register.
// A four-entry queue sits between the clamp stage and the divider pipeline.
// Reset (synchronous, active high) empties every stage and loads the default registers.
`timescale 1ns / 1ps
`default_nettype none
module mit_command_frame_encoder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [mcfe_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [mcfe_pkg::RangeW-1:0]   cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire mcfe_pkg::cmd_t                in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mcfe_pkg::frame_t                   out_data
);

  mcfe_pkg::cfg_t       cfg;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_push;
  logic                 q_pop;
  mcfe_pkg::off_word_t  push_word;
  mcfe_pkg::off_word_t  head_word;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_id         <= 11'd1;
      cfg.mode_id_offset  <= 11'd0;
      cfg.pos_limit       <= 31'd819200;
      cfg.vel_limit       <= 31'd2949120;
      cfg.tq_limit        <= 31'd1179648;
      cfg.stiffness_limit <= 31'd32768000;
      cfg.damping_limit   <= 31'd327680;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcfe_pkg::RegMotorId:    cfg.base_id         <= cfg_data[mcfe_pkg::IdW-1:0];
        mcfe_pkg::RegModeOffset: cfg.mode_id_offset  <= cfg_data[mcfe_pkg::IdW-1:0];
        mcfe_pkg::RegPosRange:   cfg.pos_limit       <= cfg_data;
        mcfe_pkg::RegVelRange:   cfg.vel_limit       <= cfg_data;
        mcfe_pkg::RegTqRange:    cfg.tq_limit        <= cfg_data;
        mcfe_pkg::RegKpLimit:    cfg.stiffness_limit <= cfg_data;
        mcfe_pkg::RegKdLimit:    cfg.damping_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  mcfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_word   (push_word)
  );

  mcfe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_word (push_word),
    .pop       (q_pop),
    .head_word (head_word),
    .full      (q_full),
    .empty     (q_empty)
  );

  mcfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_word    (head_word),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
